/* rtl/integer_to_radix_text_macros.svh */
// Assertion macros shared by the integer to radix text modules.
// Depends on signals named clk and rst in the module that uses them.
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define ITR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define ITR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/itr_pkg.sv */
// Types, constants and the digit encoding for the integer to radix text block.
// No dependencies.
package itr_pkg;

  localparam int VALUE_W        = 32;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 8;
  localparam int BITS_PER_CYCLE = 8;
  localparam int DIV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
  localparam int MAX_DIGITS     = 32;
  localparam int IDX_W          = 5;
  localparam int PTR_W          = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_TWO   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_EIGHT = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_TEN   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic pop;
    logic out_sign;
  } cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic ptr_zero;
    logic neg_form;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] start;
    if (d > 6'd9) begin
      start = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) - 8'd10;
    end else begin
      start = CHAR_ZERO;
    end
    return start + {{(CHAR_W-RADIX_W){1'b0}}, d};
  endfunction

endpackage

/* rtl/itr_if.sv */
// Channel interfaces for the integer to radix text block.
// Depends on itr_pkg for the field widths.
interface itr_num_if;
  logic                               valid;
  logic                               ready;
  logic signed [itr_pkg::VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itr_text_if;
  logic                        valid;
  logic                        ready;
  logic [itr_pkg::CHAR_W-1:0]  character;
  logic                        last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

interface itr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [itr_pkg::RADIX_W-1:0] radix;
  modport source (output valid, output radix, input ready);
  modport sink (input valid, input radix, output ready);
endinterface

/* rtl/integer_to_radix_text.sv */
// Top level of the integer to radix text block.
// Depends on itr_pkg, the channel interfaces, itr_controller and itr_datapath.
//
// Converts each signed 32-bit value into ASCII text in the base held by the radix
// register (2 to 36, values outside are clamped), most significant character first,
// with last set on the final character. Negative values in base 10 or 2 print a minus
// sign and the magnitude; in other bases the unsigned bit pattern is printed, with
// uppercase hex digits for negative values in base 16. One shared restoring divider
// retires eight quotient bits per cycle, and each digit is produced by division steps
// followed by one push onto the digit stack; the characters then leave at one per cycle
// while the receiver is ready. A new value is taken once the last character of the
// previous one has been transferred. Radix writes are always accepted.
module integer_to_radix_text (
  input  logic        clk,
  input  logic        rst,
  itr_num_if.sink     num,
  itr_text_if.source  text,
  itr_cfg_if.sink     cfg
);

  itr_pkg::cmd_t    cmd;
  itr_pkg::status_t sts;

  assign cfg.ready = 1'b1;

  itr_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .num_valid  (num.valid),
    .num_ready  (num.ready),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  itr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_radix (cfg.radix),
    .num_value (num.value),
    .cmd       (cmd),
    .sts       (sts),
    .out_char  (text.character),
    .out_last  (text.last)
  );

endmodule

/* rtl/itr_datapath.sv */
// Datapath: radix register, shared restoring divider, digit stack and output register.
// Depends on itr_pkg and the assertion macros header.
`include "integer_to_radix_text_macros.svh"

module itr_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [itr_pkg::RADIX_W-1:0]        cfg_radix,
  input  logic signed [itr_pkg::VALUE_W-1:0] num_value,
  input  itr_pkg::cmd_t                      cmd,
  output itr_pkg::status_t                   sts,
  output logic [itr_pkg::CHAR_W-1:0]         out_char,
  output logic                               out_last
);

  logic [itr_pkg::RADIX_W-1:0] radix;
  logic [itr_pkg::RADIX_W-1:0] eff_radix;
  logic [itr_pkg::RADIX_W-1:0] base;
  logic                        upper;
  logic                        neg_form;
  logic [itr_pkg::VALUE_W-1:0] mag;
  logic [itr_pkg::RADIX_W-1:0] rem;
  logic [itr_pkg::PTR_W-1:0]   ptr;
  logic [itr_pkg::CHAR_W-1:0]  stack [itr_pkg::MAX_DIGITS];

  logic [itr_pkg::VALUE_W-1:0] pattern;
  logic                        negative;
  logic                        neg_form_in;
  logic [itr_pkg::VALUE_W-1:0] mag_next;
  logic [itr_pkg::RADIX_W-1:0] rem_next;
  logic [itr_pkg::PTR_W-1:0]   ptr_dec;

  always_comb begin
    if (radix < itr_pkg::RADIX_MIN) begin
      eff_radix = itr_pkg::RADIX_MIN;
    end else if (radix > itr_pkg::RADIX_MAX) begin
      eff_radix = itr_pkg::RADIX_MAX;
    end else begin
      eff_radix = radix;
    end
  end

  assign pattern     = num_value;
  assign negative    = pattern[itr_pkg::VALUE_W-1];
  assign neg_form_in = negative &&
                       (eff_radix == itr_pkg::RADIX_TEN || eff_radix == itr_pkg::RADIX_TWO);
  assign ptr_dec     = ptr - 1'b1;

  // Restoring division, several quotient bits per cycle on a narrow remainder.
  always_comb begin
    logic [itr_pkg::RADIX_W:0] t;
    mag_next = mag;
    rem_next = rem;
    for (int i = 0; i < itr_pkg::BITS_PER_CYCLE; i++) begin
      t        = {rem_next, mag_next[itr_pkg::VALUE_W-1]};
      mag_next = {mag_next[itr_pkg::VALUE_W-2:0], 1'b0};
      if (t >= {1'b0, base}) begin
        t           = t - {1'b0, base};
        mag_next[0] = 1'b1;
      end
      rem_next = t[itr_pkg::RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itr_pkg::RADIX_RESET;
      ptr   <= '0;
    end else begin
      if (cfg_valid) begin
        radix <= cfg_radix;
      end
      if (cmd.load) begin
        ptr <= '0;
      end else if (cmd.push) begin
        ptr <= ptr + 1'b1;
      end else if (cmd.pop) begin
        ptr <= ptr_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base     <= eff_radix;
      upper    <= negative && (eff_radix == itr_pkg::RADIX_HEX);
      neg_form <= neg_form_in;
      mag      <= neg_form_in ? (~pattern + 1'b1) : pattern;
      rem      <= '0;
    end else if (cmd.div_step) begin
      mag <= mag_next;
      rem <= rem_next;
    end else if (cmd.push) begin
      rem <= '0;
    end
    if (cmd.pop) begin
      out_char <= stack[ptr_dec[itr_pkg::IDX_W-1:0]];
      out_last <= (ptr == itr_pkg::PTR_W'(1));
    end else if (cmd.out_sign) begin
      out_char <= itr_pkg::CHAR_MINUS;
      out_last <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack[ptr[itr_pkg::IDX_W-1:0]] <= itr_pkg::digit_char(rem, upper);
    end
  end

  assign sts.mag_zero = (mag == '0);
  assign sts.ptr_zero = (ptr == '0);
  assign sts.neg_form = neg_form;

  `ITR_ASSERT(a_ptr_range, (ptr <= itr_pkg::PTR_W'(itr_pkg::MAX_DIGITS)), "digit stack overflow")
  `ITR_ASSERT(a_pop_nonempty, (cmd.pop |-> ptr != '0), "pop from empty digit stack")
  `ITR_ASSERT(a_push_room, (cmd.push |-> ptr < itr_pkg::PTR_W'(itr_pkg::MAX_DIGITS)), "push to full stack")

endmodule

/* rtl/itr_controller.sv */
// Controller state machine: sequences division, digit pushes and character output.
// Depends on itr_pkg and the assertion macros header.
`include "integer_to_radix_text_macros.svh"

module itr_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             num_valid,
  output logic             num_ready,
  output logic             text_valid,
  input  logic             text_ready,
  output itr_pkg::cmd_t    cmd,
  input  itr_pkg::status_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_OUT
  } state_t;

  localparam int STEP_W = $clog2(itr_pkg::DIV_CYCLES);

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              ovalid;
  logic              sign_pending;
  logic              fire_in;
  logic              can_load;

  assign num_ready  = (state == ST_IDLE);
  assign text_valid = ovalid;
  assign fire_in    = num_valid && num_ready;
  assign can_load   = !ovalid || text_ready;

  always_comb begin
    cmd          = '0;
    cmd.load     = fire_in;
    cmd.div_step = (state == ST_DIV);
    cmd.push     = (state == ST_PUSH);
    if (state == ST_OUT && can_load) begin
      if (sign_pending) begin
        cmd.out_sign = 1'b1;
      end else if (!sts.ptr_zero) begin
        cmd.pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      ovalid       <= 1'b0;
      sign_pending <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (fire_in) begin
            state <= ST_DIV;
            step  <= '0;
          end
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(itr_pkg::DIV_CYCLES - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (sts.mag_zero) begin
            state        <= ST_OUT;
            sign_pending <= sts.neg_form;
          end else begin
            state <= ST_DIV;
            step  <= '0;
          end
        end
        ST_OUT: begin
          if (can_load) begin
            if (sign_pending) begin
              ovalid       <= 1'b1;
              sign_pending <= 1'b0;
            end else if (!sts.ptr_zero) begin
              ovalid <= 1'b1;
            end else begin
              ovalid <= 1'b0;
              state  <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ITR_ASSERT(a_no_output_in_div, ((state == ST_DIV || state == ST_PUSH) |-> !ovalid), "output during division")
  `ITR_ASSERT(a_done_goes_out, ((state == ST_PUSH && sts.mag_zero) |=> state == ST_OUT), "missed output phase")
  `ITR_ASSERT_ALWAYS(a_reset_idle, ($past(rst) |-> state == ST_IDLE && !ovalid), "not idle after reset")

endmodule
